// File: hdl/fixed_length_head_tail_deframer_unit_assert.svh
// fixed_length_head_tail_deframer_unit_assert.svh: assertion macros for the deframer checks
// no dependencies; included by the checker file
`ifndef FIXED_LENGTH_HEAD_TAIL_DEFRAMER_UNIT_ASSERT_SVH
`define FIXED_LENGTH_HEAD_TAIL_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FHTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define FHTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fhtd_pkg.sv
// fhtd_pkg: shared constants, register indexes and types of the head/tail deframer
// no dependencies; imported by fhtd_cfg and the top level
package fhtd_pkg;

  localparam int FRAME_LEN_DEF = 8;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  localparam logic [7:0] HEAD_RST = 8'hA5;
  localparam logic [7:0] TAIL_RST = 8'h5A;

  // register index, taken from paddr[2]
  localparam logic REG_HEAD = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  typedef struct packed {
    logic [7:0] head;
    logic [7:0] tail;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SCAN_RD  = 5'b00010,
    ST_SCAN_CHK = 5'b00100,
    ST_EMIT_RD  = 5'b01000,
    ST_EMIT_LD  = 5'b10000
  } state_e;

endpackage

// File: hdl/fhtd_cfg.sv
// fhtd_cfg: apb register file holding the head and tail byte values
// depends on fhtd_pkg
module fhtd_cfg
  import fhtd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output cfg_t              cfg_o
);

  logic [7:0] head_q, head_d;
  logic [7:0] tail_q, tail_d;
  logic       wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_HEAD: head_d = pwdata[7:0];
        REG_TAIL: tail_d = pwdata[7:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= HEAD_RST;
      tail_q <= TAIL_RST;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HEAD: prdata = {{(APB_DW-8){1'b0}}, head_q};
      REG_TAIL: prdata = {{(APB_DW-8){1'b0}}, tail_q};
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.head = head_q;
  assign cfg_o.tail = tail_q;

endmodule

// File: hdl/fixed_length_head_tail_deframer_unit.sv
// fixed_length_head_tail_deframer_unit: top level of the head/tail byte deframer
// depends on fhtd_pkg and fhtd_cfg
//
// Usage: received bytes come in on rx_data_i (rx_valid_i / rx_stall_o). Bytes in
// front of a head byte are thrown away. When a head has FRAME_LEN bytes behind it
// (itself included) and the last of them equals the tail value, the frame leaves
// on frame_data_o / frame_last_o (frame_valid_o / frame_stall_i), head first,
// frame_last_o high on the tail byte. On a bad tail only that head is dropped and
// the rest of the window is scanned again for a head.
// The window is a ring of FRAME_LEN bytes in a memory with one write port and one
// registered read port. Each accepted byte is written, then every window entry
// examined is read and then compared, and a scan that empties the window ends
// with a further pass through the read state. A good frame is read out byte by
// byte (read, then load) into an output register. rx_stall_o is high while a byte
// is being scanned or a frame read out; a stalled receiver holds the output
// register and the readout waits. Reset empties the window (count and pointer
// cleared, no clearing pass) and loads head 0xA5 and tail 0x5A.
module fixed_length_head_tail_deframer_unit
  import fhtd_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        rx_data_i,
  input  logic              rx_valid_i,
  output logic              rx_stall_o,
  output logic [7:0]        frame_data_o,
  output logic              frame_last_o,
  output logic              frame_valid_o,
  input  logic              frame_stall_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int PTR_W = $clog2(FRAME_LEN);
  localparam int CNT_W = $clog2(FRAME_LEN + 1);
  localparam int SUM_W = PTR_W + 1;

  cfg_t cfg;

  fhtd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign pready = 1'b1;

  state_e             state_q, state_d;
  logic [PTR_W-1:0]   front_q, front_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [7:0]         newest_q;
  logic [7:0]         out_data_q;
  logic               out_last_q;
  logic               out_valid_q, out_valid_d;

  logic [7:0]         mem_q [FRAME_LEN];
  logic [7:0]         rdata_q;
  logic               rd_en;
  logic               wr_en;
  logic [SUM_W-1:0]   wr_sum;
  logic [PTR_W-1:0]   wr_addr;
  logic [PTR_W-1:0]   front_inc;
  logic               out_load;
  logic               out_free;

  assign wr_en = rx_valid_i && (state_q == ST_IDLE);

  // ring position behind the newest byte
  assign wr_sum  = SUM_W'(front_q) + SUM_W'(count_q);
  assign wr_addr = (wr_sum >= SUM_W'(FRAME_LEN)) ? PTR_W'(wr_sum - SUM_W'(FRAME_LEN))
                                                 : PTR_W'(wr_sum);

  assign front_inc = (front_q == PTR_W'(FRAME_LEN - 1)) ? '0 : front_q + 1'b1;
  assign out_free  = !out_valid_q || !frame_stall_i;

  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    count_d  = count_q;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (wr_en) begin
          count_d = count_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (count_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (rdata_q != cfg.head) begin
          front_d = front_inc;
          count_d = count_q - 1'b1;
          state_d = ST_SCAN_RD;
        end else if (count_q == CNT_W'(FRAME_LEN)) begin
          // a full window only exists right after an append, so the tail is the newest byte
          if (newest_q == cfg.tail) begin
            state_d = ST_EMIT_RD;
          end else begin
            front_d = front_inc;
            count_d = count_q - 1'b1;
            state_d = ST_SCAN_RD;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        rd_en   = 1'b1;
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        // rdata_q holds while the output register is still occupied
        if (out_free) begin
          out_load = 1'b1;
          front_d  = front_inc;
          count_d  = count_q - 1'b1;
          state_d  = (count_q == CNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !frame_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      newest_q <= rx_data_i;
    end
    if (out_load) begin
      out_data_q <= rdata_q;
      out_last_q <= (count_q == CNT_W'(1));
    end
  end

  // window memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= rx_data_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[front_q];
    end
  end

  assign rx_stall_o    = (state_q != ST_IDLE);
  assign frame_data_o  = out_data_q;
  assign frame_last_o  = out_last_q;
  assign frame_valid_o = out_valid_q;

endmodule

// File: hdl/fhtd_checker.sv
// fhtd_checker: port-level assertions for the deframer, bound to the top level
// depends on fixed_length_head_tail_deframer_unit_assert.svh
`include "fixed_length_head_tail_deframer_unit_assert.svh"

module fhtd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_stall_o,
  input logic [7:0] frame_data_o,
  input logic       frame_last_o,
  input logic       frame_valid_o,
  input logic       frame_stall_i
);

  // a stalled result item holds
  `FHTD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, frame_valid_o && frame_stall_i, frame_valid_o && $stable(frame_data_o) && $stable(frame_last_o), "stalled result item changed")

  // every accepted byte is scanned before the next one is taken
  `FHTD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, rx_valid_i && !rx_stall_o, rx_stall_o, "input taken again without a scan")

  // input stays stalled until the whole frame has been read out
  `FHTD_ASSERT_NOW(a_stall_mid_frame, clk_i, rst_ni, frame_valid_o && !frame_last_o, rx_stall_o, "input open in the middle of a frame")

endmodule

bind fixed_length_head_tail_deframer_unit fhtd_checker u_fhtd_checker (.*);
